FILE: rtl/stoi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package stoi_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIGIT_W  = 6;
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned PROD_W   = ACC_W + RADIX_W;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 6;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_ONE  = 6'd1;
  localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
  localparam logic [DIGIT_W-1:0] NO_DIGIT   = 6'd36;

  localparam logic [0:0] CFG_RADIX = 1'b0;
  localparam logic [0:0] CFG_KIND  = 1'b1;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_START,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_U64,
    KIND_S64,
    KIND_U32,
    KIND_S32
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               is_space;
    logic               is_plus;
    logic               is_minus;
    logic               is_zero;
    logic               is_x;
    logic               last;
  } beat_t;

  typedef struct packed {
    logic [ACC_W-1:0]    acc;
    logic                negative;
    logic                overflowed;
    logic                digits_seen;
    logic [OFFSET_W-1:0] stop_offset;
    kind_t               kind;
  } snap_t;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = NO_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) d = DIGIT_W'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h7A) d = DIGIT_W'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h5A) d = DIGIT_W'(c - 8'h37);
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/stoi_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface stoi_in_if;
  logic                       valid;
  logic                       ready;
  logic [stoi_pkg::CHAR_W-1:0] char_code;
  logic                       last_char;

  modport source(output valid, output char_code, output last_char, input ready);
  modport sink(input valid, input char_code, input last_char, output ready);
endinterface

interface stoi_out_if;
  logic                         valid;
  logic                         ready;
  logic [stoi_pkg::ACC_W-1:0]    value;
  logic [stoi_pkg::STATUS_W-1:0] status;
  logic [stoi_pkg::OFFSET_W-1:0] end_offset;

  modport source(output valid, output value, output status, output end_offset, input ready);
  modport sink(input valid, input value, input status, input end_offset, output ready);
endinterface
`default_nettype wire

FILE: rtl/stoi_front.sv
`timescale 1ns / 1ps
`default_nettype none
module stoi_front (
  stoi_in_if.sink         chars,
  input  wire logic       push_ready,
  output stoi_pkg::beat_t push_beat,
  output logic            push_valid
);

  logic [stoi_pkg::CHAR_W-1:0] c;

  assign c           = chars.char_code;
  assign chars.ready = push_ready;
  assign push_valid  = chars.valid;

  always_comb begin
    push_beat.digit    = stoi_pkg::digit_of(c);
    push_beat.is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    push_beat.is_plus  = (c == 8'h2B);
    push_beat.is_minus = (c == 8'h2D);
    push_beat.is_zero  = (c == 8'h30);
    push_beat.is_x     = (c == 8'h78) || (c == 8'h58);
    push_beat.last     = chars.last_char;
  end

endmodule
`default_nettype wire

FILE: rtl/stoi_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module stoi_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  input  wire stoi_pkg::beat_t push_beat,
  output logic                 push_ready,
  output logic                 pop_valid,
  output stoi_pkg::beat_t      pop_beat,
  input  wire logic            pop
);

  stoi_pkg::beat_t                 mem [stoi_pkg::QUEUE_DEPTH];
  logic [stoi_pkg::QPTR_W-1:0]     wr_ptr;
  logic [stoi_pkg::QPTR_W-1:0]     rd_ptr;
  logic [stoi_pkg::QPTR_W:0]       count;
  logic                            push;

  assign push_ready = (count != (stoi_pkg::QPTR_W + 1)'(stoi_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop_beat   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (stoi_pkg::QPTR_W + 1)'(stoi_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

FILE: rtl/stoi_back.sv
`timescale 1ns / 1ps
`default_nettype none
module stoi_back #(
  parameter logic [15:0] POS_CAP = 16'hFFFF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [stoi_pkg::RADIX_W-1:0]   radix,
  input  wire stoi_pkg::kind_t                kind,
  input  wire logic                           q_valid,
  input  wire stoi_pkg::beat_t                beat,
  output logic                                pop,
  output logic                                fin_valid,
  output stoi_pkg::snap_t                     fin,
  input  wire logic                           fin_ready
);

  stoi_pkg::phase_t                 phase, phase_next;
  logic                             negative, negative_next;
  logic [stoi_pkg::ACC_W-1:0]       accumulator, accumulator_next;
  logic                             overflowed, overflowed_next;
  logic                             digits_seen, digits_seen_next;
  logic [stoi_pkg::RADIX_W-1:0]     active_radix, active_radix_next;
  logic [stoi_pkg::OFFSET_W-1:0]    position, position_next;
  logic [stoi_pkg::OFFSET_W-1:0]    stop_offset, stop_offset_next;
  logic [stoi_pkg::OFFSET_W-1:0]    pos_inc;
  logic [stoi_pkg::RADIX_W-1:0]     base;
  logic [stoi_pkg::PROD_W-1:0]      prod;
  logic                             begin_num;
  logic                             do_digit;

  assign pop = q_valid && (!beat.last || !fin_valid || fin_ready);

  always_ff @(posedge clk) begin
    if (rst || (pop && beat.last)) begin
      phase        <= stoi_pkg::PH_SPACE;
      negative     <= 1'b0;
      accumulator  <= '0;
      overflowed   <= 1'b0;
      digits_seen  <= 1'b0;
      active_radix <= '0;
      position     <= '0;
      stop_offset  <= '0;
    end else if (pop) begin
      phase        <= phase_next;
      negative     <= negative_next;
      accumulator  <= accumulator_next;
      overflowed   <= overflowed_next;
      digits_seen  <= digits_seen_next;
      active_radix <= active_radix_next;
      position     <= position_next;
      stop_offset  <= stop_offset_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    negative_next     = negative;
    accumulator_next  = accumulator;
    overflowed_next   = overflowed;
    digits_seen_next  = digits_seen;
    active_radix_next = active_radix;
    stop_offset_next  = stop_offset;
    pos_inc           = (position < POS_CAP) ? position + 16'd1 : POS_CAP;
    position_next     = pos_inc;
    base              = active_radix;
    begin_num         = 1'b0;
    do_digit          = 1'b0;

    case (phase)
      stoi_pkg::PH_SPACE: begin
        if (beat.is_space) begin
          stop_offset_next = pos_inc;
        end else if (beat.is_plus || beat.is_minus) begin
          negative_next    = beat.is_minus;
          stop_offset_next = pos_inc;
          phase_next       = stoi_pkg::PH_START;
        end else begin
          begin_num = 1'b1;
        end
      end
      stoi_pkg::PH_START: begin
        begin_num = 1'b1;
      end
      stoi_pkg::PH_ZERO: begin
        phase_next = stoi_pkg::PH_DIGITS;
        if (beat.is_x) begin
          active_radix_next = stoi_pkg::RADIX_HEX;
          digits_seen_next  = 1'b0;
          stop_offset_next  = pos_inc;
        end else begin
          do_digit = 1'b1;
        end
      end
      stoi_pkg::PH_DIGITS: begin
        do_digit = 1'b1;
      end
      default: begin
      end
    endcase

    if (begin_num) begin
      stop_offset_next = position;
      if (radix == stoi_pkg::RADIX_ONE || radix > stoi_pkg::RADIX_MAX) begin
        phase_next = stoi_pkg::PH_DONE;
      end else if (beat.is_zero &&
                   (radix == stoi_pkg::RADIX_AUTO || radix == stoi_pkg::RADIX_HEX)) begin
        active_radix_next = (radix == stoi_pkg::RADIX_AUTO) ? stoi_pkg::RADIX_OCT
                                                            : stoi_pkg::RADIX_HEX;
        accumulator_next  = '0;
        digits_seen_next  = 1'b1;
        stop_offset_next  = pos_inc;
        phase_next        = stoi_pkg::PH_ZERO;
      end else begin
        base              = (radix == stoi_pkg::RADIX_AUTO) ? stoi_pkg::RADIX_DEC : radix;
        active_radix_next = base;
        phase_next        = stoi_pkg::PH_DIGITS;
        do_digit          = 1'b1;
      end
    end

    prod = stoi_pkg::PROD_W'(accumulator) * stoi_pkg::PROD_W'(base)
         + stoi_pkg::PROD_W'(beat.digit);

    if (do_digit) begin
      if (base < 6'd2 || beat.digit >= base) begin
        phase_next = stoi_pkg::PH_DONE;
      end else begin
        if (!overflowed) begin
          if (prod[stoi_pkg::PROD_W-1:stoi_pkg::ACC_W] != '0) begin
            overflowed_next  = 1'b1;
            accumulator_next = '1;
          end else begin
            accumulator_next = prod[stoi_pkg::ACC_W-1:0];
          end
        end
        digits_seen_next = 1'b1;
        stop_offset_next = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else begin
      if (fin_valid && fin_ready) fin_valid <= 1'b0;
      if (pop && beat.last) fin_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && beat.last) begin
      fin.acc         <= accumulator_next;
      fin.negative    <= negative_next;
      fin.overflowed  <= overflowed_next;
      fin.digits_seen <= digits_seen_next;
      fin.stop_offset <= stop_offset_next;
      fin.kind        <= kind;
    end
  end

`ifndef SYNTH
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    pop && beat.last |=> phase == stoi_pkg::PH_SPACE && position == '0 && !overflowed)
    else $error("parser state not cleared after final beat");

  a_radix_range: assert property (@(posedge clk) disable iff (rst)
    (phase == stoi_pkg::PH_ZERO || phase == stoi_pkg::PH_DIGITS) |->
      active_radix >= 6'd2 && active_radix <= stoi_pkg::RADIX_MAX)
    else $error("active radix out of range while digits are taken");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    fin_valid && !fin_ready |=> fin_valid && $stable(fin))
    else $error("pending snapshot lost or changed");
`endif

endmodule
`default_nettype wire

FILE: rtl/stoi_shape.sv
`timescale 1ns / 1ps
`default_nettype none
module stoi_shape (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fin_valid,
  input  wire stoi_pkg::snap_t fin,
  output logic                 fin_ready,
  stoi_out_if.source           results
);

  logic [stoi_pkg::ACC_W-1:0] neg_acc;
  logic [stoi_pkg::ACC_W-1:0] v64;
  logic [stoi_pkg::ACC_W-1:0] v;
  stoi_pkg::status_t          st64;
  stoi_pkg::status_t          st;
  logic                       load;

  assign fin_ready = !results.valid || results.ready;
  assign load      = fin_valid && fin_ready;
  assign neg_acc   = -fin.acc;

  always_comb begin
    if (fin.overflowed) st64 = stoi_pkg::ST_OVERFLOW;
    else if (fin.digits_seen) st64 = stoi_pkg::ST_OK;
    else st64 = stoi_pkg::ST_INVALID;

    if (fin.kind == stoi_pkg::KIND_S64 || fin.kind == stoi_pkg::KIND_S32) begin
      if (fin.negative && fin.acc[63] && fin.acc[62:0] != '0) st64 = stoi_pkg::ST_OVERFLOW;
      if (!fin.negative && fin.acc[63]) st64 = stoi_pkg::ST_OVERFLOW;
      if (st64 == stoi_pkg::ST_OVERFLOW) begin
        v64 = fin.negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
        v64 = fin.negative ? neg_acc : fin.acc;
      end
    end else begin
      if (st64 == stoi_pkg::ST_OVERFLOW) v64 = '1;
      else v64 = fin.negative ? neg_acc : fin.acc;
    end

    v  = v64;
    st = st64;
    case (fin.kind)
      stoi_pkg::KIND_U32: begin
        if (v64[63:32] != '0) begin
          v  = 64'h0000_0000_FFFF_FFFF;
          st = stoi_pkg::ST_OVERFLOW;
        end
      end
      stoi_pkg::KIND_S32: begin
        if (!v64[63]) begin
          if (v64[62:31] != '0) begin
            v  = 64'h0000_0000_7FFF_FFFF;
            st = stoi_pkg::ST_OVERFLOW;
          end
        end else if (v64[62:31] != '1) begin
          v  = 64'h0000_0000_8000_0000;
          st = stoi_pkg::ST_OVERFLOW;
        end
        v = {32'h0, v[31:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      results.value      <= v;
      results.status     <= st;
      results.end_offset <= fin.stop_offset;
    end
  end

`ifndef SYNTH
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status == stoi_pkg::ST_INVALID |-> results.value == '0)
    else $error("invalid result carries a nonzero value");
`endif

endmodule
`default_nettype wire

FILE: rtl/string_to_integer_parser.sv
// String-to-integer parser.
// chars: one beat per character (char_code, last_char marks the final one).
// results: one beat per string, issued for the beat that carries last_char:
//   value (64 bits), status (ok, overflow, invalid) and end_offset.
// Config: write_en/write_index/write_data; index 0 is radix (0 auto, 2..36),
//   index 1 is the result kind (u64, s64, u32, s32). Write only while idle.
// Throughput: one character per cycle, sustained across string boundaries.
//   The 64x6 multiply-add of the digit accumulator is combinational.
// Path: a final character goes through the queue, the parse stage and the
//   output shaping register before its result is valid on results.
// Stall: when results is held off, one finished result waits in the output
//   register, one in the snapshot register, and the 2-entry queue keeps
//   taking characters until a further final character has nowhere to go;
//   chars.ready then drops.
// Reset: rst is synchronous; radix returns to 10, kind to unsigned 64, the
//   queue empties and the parser goes back to skipping leading whitespace.
`timescale 1ns / 1ps
`default_nettype none
module string_to_integer_parser #(
  parameter longint unsigned MAX_LENGTH = 65535
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  stoi_in_if.sink                         chars,
  stoi_out_if.source                      results,
  input  wire logic                       write_en,
  input  wire logic [0:0]                 write_index,
  input  wire logic [stoi_pkg::CFG_W-1:0] write_data
);

  localparam logic [15:0] POS_CAP = (MAX_LENGTH < 65535) ? 16'(MAX_LENGTH) : 16'hFFFF;

  logic [stoi_pkg::RADIX_W-1:0] radix;
  stoi_pkg::kind_t              kind;
  logic                         push_valid;
  logic                         push_ready;
  stoi_pkg::beat_t              push_beat;
  logic                         q_valid;
  stoi_pkg::beat_t              q_beat;
  logic                         pop;
  logic                         fin_valid;
  logic                         fin_ready;
  stoi_pkg::snap_t              fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= stoi_pkg::RADIX_DEC;
      kind  <= stoi_pkg::KIND_U64;
    end else if (write_en) begin
      case (write_index)
        stoi_pkg::CFG_RADIX: radix <= write_data;
        stoi_pkg::CFG_KIND:  kind  <= stoi_pkg::kind_t'(write_data[1:0]);
        default: begin
        end
      endcase
    end
  end

  stoi_front u_front (
    .chars      (chars),
    .push_ready (push_ready),
    .push_beat  (push_beat),
    .push_valid (push_valid)
  );

  stoi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_beat  (push_beat),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_beat   (q_beat),
    .pop        (pop)
  );

  stoi_back #(
    .POS_CAP (POS_CAP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .radix     (radix),
    .kind      (kind),
    .q_valid   (q_valid),
    .beat      (q_beat),
    .pop       (pop),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_ready (fin_ready)
  );

  stoi_shape u_shape (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_ready (fin_ready),
    .results   (results)
  );

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_CHARS = 130;
  localparam int unsigned PLAN_LEN    = 14;
  localparam logic [stoi_pkg::OFFSET_W-1:0] POS_CAP = 16'hFFFF;

  typedef logic [stoi_pkg::CHAR_W-1:0]  char_t;
  typedef logic [stoi_pkg::DIGIT_W-1:0] digit_t;
  typedef logic [stoi_pkg::PROD_W-1:0]  prod_t;
  typedef logic [stoi_pkg::CFG_W-1:0]   cfg_t;

  localparam char_t CH_SPACE = " ";
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_PLUS  = "+";
  localparam char_t CH_MINUS = "-";
  localparam char_t CH_ZERO  = "0";
  localparam char_t CH_NINE  = "9";
  localparam char_t CH_LA    = "a";
  localparam char_t CH_LZ    = "z";
  localparam char_t CH_UA    = "A";
  localparam char_t CH_UZ    = "Z";
  localparam char_t CH_LX    = "x";
  localparam char_t CH_UX    = "X";

  typedef char_t text_t[$];

  typedef struct packed {
    logic [stoi_pkg::ACC_W-1:0]    value;
    stoi_pkg::status_t             status;
    logic [stoi_pkg::OFFSET_W-1:0] end_offset;
  } parse_result_t;

  class parse_scoreboard;
    logic [stoi_pkg::RADIX_W-1:0]  radix;
    stoi_pkg::kind_t               kind;
    stoi_pkg::phase_t              phase;
    bit                            negative;
    bit                            overflowed;
    bit                            digits_seen;
    logic [stoi_pkg::RADIX_W-1:0]  active_radix;
    logic [stoi_pkg::ACC_W-1:0]    acc;
    logic [stoi_pkg::OFFSET_W-1:0] position;
    logic [stoi_pkg::OFFSET_W-1:0] stop_offset;
    parse_result_t                 pending[$];
    int                            errors;
    int                            n_results;
    int                            n_overflow;
    int                            n_invalid;

    function new();
      radix = stoi_pkg::RADIX_DEC;
      kind = stoi_pkg::KIND_U64;
      clear();
    endfunction

    function void clear();
      phase = stoi_pkg::PH_SPACE;
      negative = 0;
      overflowed = 0;
      digits_seen = 0;
      active_radix = '0;
      acc = '0;
      position = '0;
      stop_offset = '0;
    endfunction

    function void write_reg(logic [0:0] index, cfg_t data);
      if (index == stoi_pkg::CFG_RADIX) radix = data[stoi_pkg::RADIX_W-1:0];
      else kind = stoi_pkg::kind_t'(data[1:0]);
    endfunction

    function logic [stoi_pkg::OFFSET_W-1:0] next_pos();
      return (position == POS_CAP) ? POS_CAP : position + 1'b1;
    endfunction

    function digit_t char_digit(char_t c);
      if (c >= CH_ZERO && c <= CH_NINE) return digit_t'(c - CH_ZERO);
      if (c >= CH_LA && c <= CH_LZ) return digit_t'(c - CH_LA + 8'd10);
      if (c >= CH_UA && c <= CH_UZ) return digit_t'(c - CH_UA + 8'd10);
      return stoi_pkg::NO_DIGIT;
    endfunction

    function void take_digit(char_t c);
      digit_t d;
      prod_t  prod;
      d = char_digit(c);
      if (active_radix < 2 || d >= active_radix) begin
        phase = stoi_pkg::PH_DONE;
        return;
      end
      if (!overflowed) begin
        prod = prod_t'(acc) * prod_t'(active_radix) + prod_t'(d);
        if (prod[stoi_pkg::PROD_W-1:stoi_pkg::ACC_W] != '0) begin
          overflowed = 1;
          acc = '1;
        end else begin
          acc = prod[stoi_pkg::ACC_W-1:0];
        end
      end
      digits_seen = 1;
      stop_offset = next_pos();
    endfunction

    function void begin_number(char_t c);
      stop_offset = position;
      if (radix == stoi_pkg::RADIX_ONE || radix > stoi_pkg::RADIX_MAX) begin
        phase = stoi_pkg::PH_DONE;
        return;
      end
      if (c == CH_ZERO && (radix == stoi_pkg::RADIX_AUTO || radix == stoi_pkg::RADIX_HEX)) begin
        active_radix = (radix == stoi_pkg::RADIX_AUTO) ? stoi_pkg::RADIX_OCT
                                                       : stoi_pkg::RADIX_HEX;
        acc = '0;
        digits_seen = 1;
        stop_offset = next_pos();
        phase = stoi_pkg::PH_ZERO;
        return;
      end
      active_radix = (radix == stoi_pkg::RADIX_AUTO) ? stoi_pkg::RADIX_DEC : radix;
      phase = stoi_pkg::PH_DIGITS;
      take_digit(c);
    endfunction

    function parse_result_t shape();
      parse_result_t r;
      logic [stoi_pkg::ACC_W-1:0] v;
      stoi_pkg::status_t st;
      st = overflowed ? stoi_pkg::ST_OVERFLOW
                      : (digits_seen ? stoi_pkg::ST_OK : stoi_pkg::ST_INVALID);
      if (kind == stoi_pkg::KIND_U64 || kind == stoi_pkg::KIND_U32) begin
        if (st == stoi_pkg::ST_OVERFLOW) v = '1;
        else v = negative ? -acc : acc;
        if (kind == stoi_pkg::KIND_U32 && v > 64'hFFFF_FFFF) begin
          v = 64'hFFFF_FFFF;
          st = stoi_pkg::ST_OVERFLOW;
        end
      end else begin
        if (negative && acc > 64'h8000_0000_0000_0000) st = stoi_pkg::ST_OVERFLOW;
        if (!negative && acc > 64'h7FFF_FFFF_FFFF_FFFF) st = stoi_pkg::ST_OVERFLOW;
        if (st == stoi_pkg::ST_OVERFLOW)
          v = negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        else
          v = negative ? -acc : acc;
        if (kind == stoi_pkg::KIND_S32) begin
          if (!v[63]) begin
            if (v > 64'h7FFF_FFFF) begin
              v = 64'h7FFF_FFFF;
              st = stoi_pkg::ST_OVERFLOW;
            end
          end else if (v < 64'hFFFF_FFFF_8000_0000) begin
            v = 64'h8000_0000;
            st = stoi_pkg::ST_OVERFLOW;
          end
          v = v & 64'hFFFF_FFFF;
        end
      end
      r.value = v;
      r.status = st;
      r.end_offset = stop_offset;
      return r;
    endfunction

    function void note_char(char_t c, bit last);
      case (phase)
        stoi_pkg::PH_SPACE: begin
          if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            stop_offset = next_pos();
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            negative = (c == CH_MINUS);
            stop_offset = next_pos();
            phase = stoi_pkg::PH_START;
          end else begin
            begin_number(c);
          end
        end
        stoi_pkg::PH_START: begin_number(c);
        stoi_pkg::PH_ZERO: begin
          phase = stoi_pkg::PH_DIGITS;
          if (c == CH_LX || c == CH_UX) begin
            active_radix = stoi_pkg::RADIX_HEX;
            digits_seen = 0;
            stop_offset = next_pos();
          end else begin
            take_digit(c);
          end
        end
        stoi_pkg::PH_DIGITS: take_digit(c);
        default: ;
      endcase
      position = next_pos();
      if (last) begin
        pending.push_back(shape());
        clear();
      end
    endfunction

    function void check_result(logic [stoi_pkg::ACC_W-1:0] v,
                               logic [stoi_pkg::STATUS_W-1:0] st,
                               logic [stoi_pkg::OFFSET_W-1:0] off);
      parse_result_t want;
      if (pending.size() == 0) begin
        $error("result with nothing pending: value %h status %0d end_offset %0d", v, st, off);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (v !== want.value) begin
        $error("value: expected %h, got %h", want.value, v);
        errors++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (off !== want.end_offset) begin
        $error("end_offset: expected %0d, got %0d", want.end_offset, off);
        errors++;
      end
      n_results++;
      if (want.status == stoi_pkg::ST_OVERFLOW) n_overflow++;
      if (want.status == stoi_pkg::ST_INVALID) n_invalid++;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               write_en;
  logic [0:0]         write_index;
  cfg_t               write_data;
  int                 n_chars = 0;
  int                 burst_left = 0;
  int                 quiet = 0;
  bit                 hold_request = 0;
  parse_scoreboard    sb = new();

  stoi_in_if  chars();
  stoi_out_if results();

  string_to_integer_parser i_dut (
    .clk         (clk),
    .rst         (rst),
    .chars       (chars),
    .results     (results),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (chars.valid && chars.ready) || (results.valid && results.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("[string_to_integer_parser] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int mode;
    int window;
    int hold_left;
    int tick;
    mode = 0;
    window = 0;
    hold_left = 0;
    tick = 0;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results.valid && results.ready)
        sb.check_result(results.value, results.status, results.end_offset);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        results.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 0;
        hold_left = HOLD_CYCLES;
        results.ready <= 1'b0;
      end else begin
        if (window == 0) begin
          mode = $urandom_range(0, 4);
          window = $urandom_range(16, 96);
        end
        window--;
        case (mode)
          0: results.ready <= 1'b1;
          1: results.ready <= ($urandom_range(0, 3) != 0);
          2: results.ready <= 1'($urandom_range(0, 1));
          3: results.ready <= ((tick % 5) < 3);
          default: results.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic text_t text_of(string str);
    text_t t;
    foreach (str[i]) t.push_back(str[i]);
    return t;
  endfunction

  function automatic char_t digit_char(int d);
    if (d < 10) return CH_ZERO + char_t'(d);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + char_t'(d - 10);
  endfunction

  function automatic char_t space_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : CH_TAB + char_t'(k);
  endfunction

  function automatic logic [stoi_pkg::ACC_W:0] pick_value();
    logic [stoi_pkg::ACC_W:0] v;
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: v = 65'h0_FFFF_FFFF_FFFF_FFFF;
      1: v = 65'h0_8000_0000_0000_0000;
      2: v = 65'h0_7FFF_FFFF_FFFF_FFFF;
      3: v = 65'h0_0000_0000_FFFF_FFFF;
      4: v = 65'h0_0000_0000_8000_0000;
      5: v = 65'h0_0000_0000_7FFF_FFFF;
      6: v = '0;
      default: v = {1'b0, $urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    if (k < 6) v = v + 65'($urandom_range(0, 4)) - 65'd2;
    return v;
  endfunction

  task automatic make_string(output text_t s);
    int pick;
    int digs[$];
    logic [stoi_pkg::ACC_W:0] v;
    logic [stoi_pkg::RADIX_W-1:0] base;
    bit hex_prefix;
    bit zero_prefix;
    s = {};
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 8)) s.push_back(char_t'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 3)) s.push_back(space_char());
    if (pick < 14) begin
      if ($urandom_range(0, 1)) s.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      if (s.size() == 0) s.push_back(space_char());
      return;
    end
    case ($urandom_range(0, 2))
      1: s.push_back(CH_PLUS);
      2: s.push_back(CH_MINUS);
      default: ;
    endcase
    base = (sb.radix >= 2 && sb.radix <= stoi_pkg::RADIX_MAX) ? sb.radix
                                                              : stoi_pkg::RADIX_DEC;
    hex_prefix = 0;
    zero_prefix = 0;
    if (sb.radix == stoi_pkg::RADIX_AUTO || sb.radix == stoi_pkg::RADIX_HEX) begin
      case ($urandom_range(0, 3))
        0: hex_prefix = 1;
        1: zero_prefix = (sb.radix == stoi_pkg::RADIX_AUTO);
        default: ;
      endcase
    end
    if (hex_prefix) begin
      s.push_back(CH_ZERO);
      s.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
      base = stoi_pkg::RADIX_HEX;
    end else if (zero_prefix) begin
      s.push_back(CH_ZERO);
      base = stoi_pkg::RADIX_OCT;
    end
    if ($urandom_range(0, 9) != 0) begin
      v = pick_value();
      do begin
        digs.push_back(int'(v % base));
        v = v / base;
      end while (v != 0);
      if ($urandom_range(0, 6) == 0) digs.push_front($urandom_range(0, base - 1));
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) digs.push_back(0);
      for (int i = digs.size() - 1; i >= 0; i--) s.push_back(digit_char(digs[i]));
    end
    repeat ($urandom_range(0, 3)) s.push_back(char_t'($urandom_range(0, 255)));
    if (s.size() == 0) s.push_back(char_t'($urandom_range(0, 255)));
  endtask

  task automatic send_char(input char_t c, input bit last, input bit paced);
    int gap;
    if (paced) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        case ($urandom_range(0, 9))
          0, 1, 2: gap = 0;
          3: gap = $urandom_range(10, 40);
          default: gap = $urandom_range(1, 4);
        endcase
        if (gap > 0) begin
          chars.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    chars.valid <= 1'b1;
    chars.char_code <= c;
    chars.last_char <= last;
    do @(posedge clk); while (chars.ready !== 1'b1);
    sb.note_char(c, last);
    n_chars++;
  endtask

  task automatic send_text(input text_t s, input bit paced);
    foreach (s[i]) send_char(s[i], i == s.size() - 1, paced);
  endtask

  task automatic wait_drain();
    chars.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] index, input cfg_t data);
    write_en <= 1'b1;
    write_index <= index;
    write_data <= data;
    @(posedge clk);
    write_en <= 1'b0;
    sb.write_reg(index, data);
  endtask

  initial begin
    logic [stoi_pkg::RADIX_W-1:0] radix_plan[PLAN_LEN];
    stoi_pkg::kind_t kind_plan[PLAN_LEN];
    text_t s;
    int budget;
    radix_plan = '{6'd0, 6'd16, 6'd2, 6'd36, 6'd8, 6'd1, 6'd63,
                   6'd37, 6'd0, 6'd16, 6'd10, 6'd10, 6'd7, 6'd0};
    kind_plan = '{stoi_pkg::KIND_U64, stoi_pkg::KIND_S64, stoi_pkg::KIND_U32,
                  stoi_pkg::KIND_S32, stoi_pkg::KIND_S64, stoi_pkg::KIND_U64,
                  stoi_pkg::KIND_U32, stoi_pkg::KIND_S32, stoi_pkg::KIND_S32,
                  stoi_pkg::KIND_U32, stoi_pkg::KIND_S64, stoi_pkg::KIND_U64,
                  stoi_pkg::KIND_S32, stoi_pkg::KIND_S64};
    rst <= 1'b1;
    chars.valid <= 1'b0;
    chars.char_code <= '0;
    chars.last_char <= 1'b0;
    write_en <= 1'b0;
    write_index <= '0;
    write_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_text(text_of("\t-12a"), 1);
    send_text(text_of(" +"), 1);
    s = {};
    s.push_back(8'hFF);
    send_text(s, 1);
    s = {};
    s.push_back(8'h00);
    send_text(s, 1);
    send_text(text_of("0"), 1);
    send_text(text_of("  "), 1);
    send_text(text_of("99x9"), 1);
    send_text(text_of("-0"), 1);

    for (int p = 0; p < PLAN_LEN; p++) begin
      wait_drain();
      write_reg(stoi_pkg::CFG_RADIX, radix_plan[p]);
      write_reg(stoi_pkg::CFG_KIND,
                {cfg_t'($urandom_range(0, 15)) << 2} | cfg_t'(kind_plan[p]));
      if (p == 1) hold_request = 1;
      budget = n_chars + PHASE_CHARS;
      while (n_chars < budget) begin
        make_string(s);
        send_text(s, 1);
        if ($urandom_range(0, 29) == 0) wait_drain();
      end
    end

    wait_drain();
    repeat (8) @(posedge clk);
    $display("covered %0d characters and %0d results (%0d overflow, %0d invalid)",
             n_chars, sb.n_results, sb.n_overflow, sb.n_invalid);
    $display("across %0d radix and result-kind settings, with a long output hold-off",
             PLAN_LEN + 1);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[string_to_integer_parser] OK");
    end else begin
      $display("[string_to_integer_parser] ERROR");
    end
    $finish;
  end
endmodule
